[src/d8sdr_pkg.sv]
package d8sdr_pkg;

    localparam int NUM_DIRS   = 8;
    localparam int DIR_BITS   = 4;
    localparam int SLOPE_BITS = 48;
    localparam int RECIP_BITS = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [DIR_BITS-1:0]   NO_FLOW_DIR = 4'd8;
    localparam logic [SLOPE_BITS-1:0] SLOPE_MAX   = {SLOPE_BITS{1'b1}};

    localparam logic [RECIP_BITS-1:0] RECIP_ORTH_RESET = 32'd65536;
    localparam logic [RECIP_BITS-1:0] RECIP_DIAG_RESET = 32'd46341;

    localparam logic REG_RECIP_ORTH = 1'b0;
    localparam logic REG_RECIP_DIAG = 1'b1;

    typedef struct packed {
        logic [SLOPE_BITS-1:0] slope;
        logic [DIR_BITS-1:0]   dir;
    } t_cand;

    // The left candidate covers the lower directions, so it keeps ties.
    function automatic t_cand pick_steeper(input t_cand a, input t_cand b);
        t_cand res;
        if (b.slope > a.slope) begin
            res = b;
        end else begin
            res = a;
        end
        return res;
    endfunction

endpackage

[src/d8_steepest_descent_receiver.sv]
// D8 steepest-descent receiver.
// A cell passes the input, drop, partial-product, slope, tree and output registers in order.
// Throughput: one cell per cycle unless the output stalls, through the six-stage pipeline.
// A stalled output holds the whole pipeline; input stall follows output stall.
// Synchronous active-low reset clears the stage valid bits and loads the default reciprocals.
// Input is stalled while reset is held.
module d8_steepest_descent_receiver
    import d8sdr_pkg::*;
#(
    parameter int HEIGHT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [HEIGHT_BITS-1:0] i_center_height,
    input  logic signed [HEIGHT_BITS-1:0] i_west_height,
    input  logic signed [HEIGHT_BITS-1:0] i_northwest_height,
    input  logic signed [HEIGHT_BITS-1:0] i_north_height,
    input  logic signed [HEIGHT_BITS-1:0] i_northeast_height,
    input  logic signed [HEIGHT_BITS-1:0] i_east_height,
    input  logic signed [HEIGHT_BITS-1:0] i_southeast_height,
    input  logic signed [HEIGHT_BITS-1:0] i_south_height,
    input  logic signed [HEIGHT_BITS-1:0] i_southwest_height,
    input  logic                          i_is_border,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [DIR_BITS-1:0]           o_receiver_dir,
    output logic [SLOPE_BITS-1:0]         o_steepest_slope,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_BITS-1:0]      paddr,
    input  logic [APB_DATA_BITS-1:0]      pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    localparam int HI_BITS   = (HEIGHT_BITS > 32) ? HEIGHT_BITS - 32 : 1;
    localparam int EXT_BITS  = 64;
    localparam int P0_BITS   = 64;
    localparam int P1_BITS   = HI_BITS + RECIP_BITS;
    localparam int NUM_STAGE = 6;

    logic [RECIP_BITS-1:0] r_recip_orth;
    logic [RECIP_BITS-1:0] r_recip_diag;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip_orth <= RECIP_ORTH_RESET;
            r_recip_diag <= RECIP_DIAG_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_RECIP_ORTH: r_recip_orth <= pwdata;
                REG_RECIP_DIAG: r_recip_diag <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RECIP_ORTH: prdata = r_recip_orth;
            REG_RECIP_DIAG: prdata = r_recip_diag;
            default:        prdata = '0;
        endcase
    end

    logic [NUM_STAGE-1:0] r_vld;
    logic                 en;

    assign en      = !(r_vld[NUM_STAGE-1] && i_stall);
    assign o_stall = !en || !i_rst_n;
    assign o_valid = r_vld[NUM_STAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STAGE-2:0], i_valid};
        end
    end

    // Input register.
    logic [HEIGHT_BITS-1:0] r_center;
    logic [HEIGHT_BITS-1:0] r_nb [NUM_DIRS];
    logic                   r_border;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_center <= i_center_height;
            r_nb[0]  <= i_west_height;
            r_nb[1]  <= i_northwest_height;
            r_nb[2]  <= i_north_height;
            r_nb[3]  <= i_northeast_height;
            r_nb[4]  <= i_east_height;
            r_nb[5]  <= i_southeast_height;
            r_nb[6]  <= i_south_height;
            r_nb[7]  <= i_southwest_height;
            r_border <= i_is_border;
        end
    end

    // Height drops; a flat or uphill neighbor, or a border cell, gives a zero drop.
    logic [HEIGHT_BITS-1:0] c_off;
    logic [HEIGHT_BITS-1:0] nb_off [NUM_DIRS];
    logic [HEIGHT_BITS-1:0] n_drop [NUM_DIRS];
    logic [HEIGHT_BITS-1:0] r_drop [NUM_DIRS];

    always_comb begin
        c_off = {~r_center[HEIGHT_BITS-1], r_center[HEIGHT_BITS-2:0]};
        for (int n = 0; n < NUM_DIRS; n++) begin
            nb_off[n] = {~r_nb[n][HEIGHT_BITS-1], r_nb[n][HEIGHT_BITS-2:0]};
            if (!r_border && (c_off > nb_off[n])) begin
                n_drop[n] = c_off - nb_off[n];
            end else begin
                n_drop[n] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drop <= n_drop;
        end
    end

    // Partial products of drop and reciprocal.
    logic [EXT_BITS-1:0]   drop_ext [NUM_DIRS];
    logic [RECIP_BITS-1:0] recip    [NUM_DIRS];
    logic [P0_BITS-1:0]    n_p0     [NUM_DIRS];
    logic [P1_BITS-1:0]    n_p1     [NUM_DIRS];
    logic [P0_BITS-1:0]    r_p0     [NUM_DIRS];
    logic [P1_BITS-1:0]    r_p1     [NUM_DIRS];

    always_comb begin
        for (int n = 0; n < NUM_DIRS; n++) begin
            drop_ext[n] = {{(EXT_BITS-HEIGHT_BITS){1'b0}}, r_drop[n]};
            recip[n]    = n[0] ? r_recip_diag : r_recip_orth;
            n_p0[n]     = P0_BITS'(drop_ext[n][31:0]) * P0_BITS'(recip[n]);
            n_p1[n]     = P1_BITS'(drop_ext[n][32 +: HI_BITS]) * P1_BITS'(recip[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
        end
    end

    // Combine to unsigned Q48.0 and saturate.
    logic [SLOPE_BITS:0]   slope_sum [NUM_DIRS];
    logic [SLOPE_BITS-1:0] n_slope   [NUM_DIRS];
    logic [SLOPE_BITS-1:0] r_slope   [NUM_DIRS];

    always_comb begin
        for (int n = 0; n < NUM_DIRS; n++) begin
            slope_sum[n] = {1'b0, r_p1[n][31:0], 16'd0} + {1'b0, r_p0[n][63:16]};
            if ((r_p1[n][P1_BITS-1:32] != '0) || slope_sum[n][SLOPE_BITS]) begin
                n_slope[n] = SLOPE_MAX;
            end else begin
                n_slope[n] = slope_sum[n][SLOPE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_slope <= n_slope;
        end
    end

    // First two levels of the selection tree.
    t_cand cand [NUM_DIRS];
    t_cand lvl1 [NUM_DIRS/2];
    t_cand n_lvl2 [NUM_DIRS/4];
    t_cand r_lvl2 [NUM_DIRS/4];

    always_comb begin
        for (int n = 0; n < NUM_DIRS; n++) begin
            cand[n].slope = r_slope[n];
            cand[n].dir   = (r_slope[n] == '0) ? NO_FLOW_DIR : DIR_BITS'(n);
        end
        for (int k = 0; k < NUM_DIRS/2; k++) begin
            lvl1[k] = pick_steeper(cand[2*k], cand[2*k+1]);
        end
        for (int j = 0; j < NUM_DIRS/4; j++) begin
            n_lvl2[j] = pick_steeper(lvl1[2*j], lvl1[2*j+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lvl2 <= n_lvl2;
        end
    end

    // Final selection into the output register.
    t_cand n_best;
    t_cand r_best;

    assign n_best = pick_steeper(r_lvl2[0], r_lvl2[1]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_best <= n_best;
        end
    end

    assign o_receiver_dir   = r_best.dir;
    assign o_steepest_slope = r_best.slope;

endmodule
